// ===== rtl/ovnh_pkg.sv =====
`timescale 1ns / 1ps

package ovnh_pkg;

    localparam int CHUNK_WIDTH_DEF       = 16;
    localparam int MAX_OCTAVES_DEF       = 16;
    localparam int WEIGHT_TABLE_BITS_DEF = 8;

    localparam int CHUNK_FIELD_W = 21;
    localparam int LOCAL_W       = 4;
    localparam int HEIGHT_W      = 24;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_IDX_W     = 3;
    localparam int SMOOTH_W      = 12;
    localparam int QUO_W         = 48;
    localparam int OCT_W         = 7;
    localparam int TOTAL_W       = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SCALE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHNESS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUGHNESS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED          = 3'd5;

    localparam logic [31:0] HASH_MUL = 32'd60493;
    localparam logic [31:0] HASH_C2  = 32'd19990303;
    localparam logic [31:0] HASH_C3  = 32'd1376312589;
    // ceil(2^33 / 21), exact for dividends below 2^29
    localparam logic [32:0] RECIP_21    = 33'd409044505;
    localparam int          RECIP_SHIFT = 33;
    localparam logic signed [TOTAL_W-1:0] HEIGHT_BIAS = 24'sd78643;

    localparam longint unsigned TAYLOR_DEN [10] = '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380};

    typedef struct packed {
        logic start;
        logic step;
    } div_ctl_t;

    function automatic logic [16:0] wt_entry(int unsigned idx, int unsigned bits);
        longint unsigned theta;
        longint unsigned x2;
        longint unsigned term;
        longint          c;
        longint          d;
        theta = ((longint'(idx) * 314) << 24) / 100 >> bits;
        x2    = (theta * theta) >> 24;
        term  = 64'd1 << 24;
        c     = longint'(term);
        for (int k = 1; k <= 10; k++)
        begin
            term = ((term * x2) >> 24) / TAYLOR_DEN[k-1];
            if ((k % 2) == 1)
                c = c - longint'(term);
            else
                c = c + longint'(term);
        end
        d = (longint'(1) << 24) - c;
        if (d < 0)
            d = 0;
        d = (d + 256) >>> 9;
        if (d > 65536)
            d = 65536;
        return 17'(d);
    endfunction

endpackage

// ===== rtl/ovnh_mul.sv =====
`timescale 1ns / 1ps

module ovnh_mul (
    input  logic               clk,
    input  logic signed [32:0] op_a,
    input  logic signed [32:0] op_b,
    output logic signed [65:0] prod
);
    logic signed [65:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= 66'(op_a) * 66'(op_b);
    end

    assign prod = prod_reg;
endmodule

// ===== rtl/ovnh_div.sv =====
`timescale 1ns / 1ps

module ovnh_div #(
    parameter int DW = 43
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ovnh_pkg::div_ctl_t                  ctl,
    input  logic [DW-1:0]                       dividend_x,
    input  logic [DW-1:0]                       dividend_z,
    input  logic [ovnh_pkg::SMOOTH_W-1:0]       divisor,
    output logic                                done,
    output logic [ovnh_pkg::QUO_W-1:0]          quo_x,
    output logic [ovnh_pkg::QUO_W-1:0]          quo_z
);
    import ovnh_pkg::*;

    localparam int CW = (DW > 1) ? $clog2(DW) : 1;

    logic                busy_reg;
    logic [CW-1:0]       cnt_reg;
    logic [SMOOTH_W-1:0] d_reg;
    logic [DW-1:0]       sh_reg   [2];
    logic [SMOOTH_W-1:0] rem_reg  [2];
    logic [QUO_W-1:0]    q_reg    [2];
    logic [DW-1:0]       sh_next  [2];
    logic [SMOOTH_W-1:0] rem_next [2];
    logic [QUO_W-1:0]    q_next   [2];
    logic                last;
    logic                iterate;

    assign last    = (cnt_reg == CW'(DW - 1));
    assign done    = busy_reg && last;
    assign iterate = busy_reg || ctl.step;

    // one restoring step per lane
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            logic [SMOOTH_W:0] rem_ext;
            logic              ge;
            rem_ext     = {rem_reg[l], sh_reg[l][DW-1]};
            ge          = (rem_ext >= {1'b0, d_reg});
            rem_next[l] = ge ? SMOOTH_W'(rem_ext - {1'b0, d_reg}) : SMOOTH_W'(rem_ext);
            sh_next[l]  = {sh_reg[l][DW-2:0], 1'b0};
            q_next[l]   = {q_reg[l][QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctl.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (last)
                busy_reg <= 1'b0;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            d_reg      <= divisor;
            sh_reg[0]  <= dividend_x;
            sh_reg[1]  <= dividend_z;
            rem_reg[0] <= '0;
            rem_reg[1] <= '0;
            q_reg[0]   <= '0;
            q_reg[1]   <= '0;
        end
        else if (iterate)
        begin
            for (int l = 0; l < 2; l++)
            begin
                sh_reg[l]  <= sh_next[l];
                rem_reg[l] <= rem_next[l];
                q_reg[l]   <= q_next[l];
            end
        end
    end

    assign quo_x = q_reg[0];
    assign quo_z = q_reg[1];
endmodule

// ===== rtl/octave_value_noise_height_unit.sv =====
`timescale 1ns / 1ps

// octave value-noise terrain height, one column per item
// input channel: an item (local_x, local_z, chunk_x, chunk_z) is taken at a
// rising edge with start high and busy low; busy stays high until the result
// result channel: done is high for one cycle with height_q8 valid; the receiver
// cannot stall, so the result is simply presented and dropped after that cycle
// config: cfg_we writes cfg_data to the register at cfg_index (0 octave_count,
// 1 height_scale, 2 smoothness, 3 height_offset, 4 roughness_q16, 5 seed)
// the result strobe comes in the cycle in which busy falls, and a new item may
// start in that cycle; the restoring divider, with DW = 21 + log2(CHUNK_WIDTH) + 18
// bit dividends, sets the coordinate scaling and is stepped once more after each
// octave; each octave hashes its four corners and then blends them on the one
// shared multiplier, and the final normalisation (FIN, FDIV, SCALE, OUT) also
// uses it; one item at a time
// reset returns the registers to their defaults and the block to idle;
// the weight table is a constant and needs no fill

module octave_value_noise_height_unit #(
    parameter int CHUNK_WIDTH       = ovnh_pkg::CHUNK_WIDTH_DEF,
    parameter int MAX_OCTAVES       = ovnh_pkg::MAX_OCTAVES_DEF,
    parameter int WEIGHT_TABLE_BITS = ovnh_pkg::WEIGHT_TABLE_BITS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    output logic                                     busy,
    input  logic [ovnh_pkg::LOCAL_W-1:0]             local_x,
    input  logic [ovnh_pkg::LOCAL_W-1:0]             local_z,
    input  logic signed [ovnh_pkg::CHUNK_FIELD_W-1:0] chunk_x,
    input  logic signed [ovnh_pkg::CHUNK_FIELD_W-1:0] chunk_z,
    output logic                                     done,
    output logic [ovnh_pkg::HEIGHT_W-1:0]            height_q8,
    input  logic                                     cfg_we,
    input  logic [ovnh_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [ovnh_pkg::CFG_DATA_W-1:0]          cfg_data
);
    import ovnh_pkg::*;

    localparam int WW      = CHUNK_FIELD_W + $clog2(CHUNK_WIDTH) + 2;
    localparam int DW      = WW + 16;
    localparam int WT_SIZE = 1 << WEIGHT_TABLE_BITS;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_DIV   = 8'b0000_0010,
        ST_HASH  = 8'b0000_0100,
        ST_BLEND = 8'b0000_1000,
        ST_FIN   = 8'b0001_0000,
        ST_FDIV  = 8'b0010_0000,
        ST_SCALE = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    logic [4:0]         octave_count_reg;
    logic [9:0]         height_scale_reg;
    logic [11:0]        smoothness_reg;
    logic signed [9:0]  height_offset_reg;
    logic [15:0]        roughness_reg;
    logic [31:0]        seed_reg;

    state_t             state_reg;
    logic               sign_x_reg;
    logic               sign_z_reg;
    logic [OCT_W-1:0]   cnt_reg;
    logic [OCT_W-1:0]   oct_reg;
    logic [1:0]         sel_reg;
    logic [2:0]         phase_reg;
    logic [16:0]        amp_reg;
    logic signed [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] fq_reg;
    logic signed [17:0] r1_reg;
    logic signed [17:0] corner_reg [4];
    logic               done_reg;
    logic [HEIGHT_W-1:0] height_reg;

    logic [16:0]        wt_rom [WT_SIZE];

    for (genvar gi = 0; gi < WT_SIZE; gi++)
    begin : g_wt
        assign wt_rom[gi] = wt_entry(gi, WEIGHT_TABLE_BITS);
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octave_count_reg  <= 5'd7;
            height_scale_reg  <= 10'd70;
            smoothness_reg    <= 12'd235;
            height_offset_reg <= -10'sd5;
            roughness_reg     <= 16'd34734;
            seed_reg          <= 32'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OCTAVE_COUNT:  octave_count_reg  <= cfg_data[4:0];
                CFG_HEIGHT_SCALE:  height_scale_reg  <= cfg_data[9:0];
                CFG_SMOOTHNESS:    smoothness_reg    <= cfg_data[11:0];
                CFG_HEIGHT_OFFSET: height_offset_reg <= $signed(cfg_data[9:0]);
                CFG_ROUGHNESS:     roughness_reg     <= cfg_data[15:0];
                CFG_SEED:          seed_reg          <= cfg_data;
                default:           ;
            endcase
        end
    end

    // world coordinates
    logic signed [WW-1:0] wx;
    logic signed [WW-1:0] wz;
    logic [WW-1:0]        mag_x;
    logic [WW-1:0]        mag_z;
    logic [SMOOTH_W-1:0]  s_eff;
    logic [OCT_W-1:0]     cnt_eff;
    logic                 accept;

    assign accept  = start && (state_reg == ST_IDLE);
    assign wx      = WW'($signed({1'b0, local_x})) + WW'(chunk_x) * WW'(CHUNK_WIDTH);
    assign wz      = WW'($signed({1'b0, local_z})) + WW'(chunk_z) * WW'(CHUNK_WIDTH);
    assign mag_x   = wx[WW-1] ? WW'(-wx) : WW'(wx);
    assign mag_z   = wz[WW-1] ? WW'(-wz) : WW'(wz);
    assign s_eff   = (smoothness_reg == '0) ? SMOOTH_W'(1) : smoothness_reg;
    assign cnt_eff = (OCT_W'(octave_count_reg) > OCT_W'(MAX_OCTAVES)) ?
                     OCT_W'(MAX_OCTAVES) : OCT_W'(octave_count_reg);

    // shared units
    div_ctl_t           div_ctl;
    logic [DW-1:0]      div_dx;
    logic [DW-1:0]      div_dz;
    logic [SMOOTH_W-1:0] div_d;
    logic               div_done;
    logic [QUO_W-1:0]   quo_x;
    logic [QUO_W-1:0]   quo_z;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;

    ovnh_div #(
        .DW(DW)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (div_ctl),
        .dividend_x (div_dx),
        .dividend_z (div_dz),
        .divisor    (div_d),
        .done       (div_done),
        .quo_x      (quo_x),
        .quo_z      (quo_z)
    );

    ovnh_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    // lattice point and weights
    logic [31:0] ix;
    logic [31:0] iz;
    logic [16:0] gx;
    logic [16:0] gz;
    logic [31:0] n0;
    logic [31:0] hn;
    logic [31:0] prod_lo;
    logic [31:0] hv;
    logic signed [17:0] corner_val;
    logic signed [33:0] sh16;
    logic signed [17:0] r1_now;
    logic signed [17:0] r2_now;
    logic signed [17:0] r3_now;

    assign ix = sign_x_reg ? (32'd0 - quo_x[QUO_W-1:16]) : quo_x[QUO_W-1:16];
    assign iz = sign_z_reg ? (32'd0 - quo_z[QUO_W-1:16]) : quo_z[QUO_W-1:16];
    assign gx = wt_rom[quo_x[15 -: WEIGHT_TABLE_BITS]];
    assign gz = wt_rom[quo_z[15 -: WEIGHT_TABLE_BITS]];

    assign n0         = (ix + 32'(sel_reg[0])) + (iz + 32'(sel_reg[1])) * 32'd57 + seed_reg;
    assign hn         = (n0 << 13) ^ n0;
    assign prod_lo    = mul_p[31:0];
    assign hv         = prod_lo + HASH_C3;
    assign corner_val = 18'sd65536 - $signed({1'b0, hv[30:14]});
    assign sh16       = mul_p[49:16];
    assign r1_now     = corner_reg[0] + 18'(sh16);
    assign r2_now     = corner_reg[2] + 18'(sh16);
    assign r3_now     = r1_reg + 18'(sh16);

    // final normalisation
    logic                      tot_neg;
    logic [TOTAL_W-1:0]        tot_mag;
    logic [27:0]               tot10;
    logic signed [TOTAL_W-1:0] hq;
    logic signed [33:0]        pv;
    logic [HEIGHT_W-1:0]       height_val;

    assign tot_neg = total_reg[TOTAL_W-1];
    assign tot_mag = tot_neg ? TOTAL_W'(-total_reg) : TOTAL_W'(total_reg);
    assign tot10   = 28'(tot_mag) * 28'd10 + (tot_neg ? 28'd20 : 28'd0);
    assign hq      = (tot_neg ? $signed(TOTAL_W'(-fq_reg)) : $signed(fq_reg)) + HEIGHT_BIAS;
    assign pv      = mul_p[33:0] + {{8{height_offset_reg[9]}}, height_offset_reg, 16'd0};

    always_comb
    begin
        if (pv <= 0)
            height_val = HEIGHT_W'(256);
        else if (pv[33:32] != 2'b00)
            height_val = '1;
        else
            height_val = pv[31:8];
    end

    // shared unit operands
    always_comb
    begin
        div_ctl = '0;
        div_dx  = DW'(mag_x) << 16;
        div_dz  = DW'(mag_z) << 16;
        div_d   = s_eff;
        mul_a   = '0;
        mul_b   = '0;
        case (state_reg)
            ST_IDLE:
            begin
                div_ctl.start = accept;
            end
            ST_HASH:
            begin
                case (phase_reg)
                    3'd0:
                    begin
                        mul_a = {1'b0, hn};
                        mul_b = {1'b0, hn};
                    end
                    3'd1:
                    begin
                        mul_a = {1'b0, prod_lo};
                        mul_b = {1'b0, HASH_MUL};
                    end
                    3'd2:
                    begin
                        mul_a = {1'b0, hn};
                        mul_b = {1'b0, prod_lo + HASH_C2};
                    end
                    default: ;
                endcase
            end
            ST_BLEND:
            begin
                case (phase_reg)
                    3'd0:
                    begin
                        mul_a = 33'(19'(corner_reg[1]) - 19'(corner_reg[0]));
                        mul_b = {16'd0, gx};
                    end
                    3'd1:
                    begin
                        mul_a = 33'(19'(corner_reg[3]) - 19'(corner_reg[2]));
                        mul_b = {16'd0, gx};
                    end
                    3'd2:
                    begin
                        mul_a = 33'(19'(r2_now) - 19'(r1_reg));
                        mul_b = {16'd0, gz};
                    end
                    3'd3:
                    begin
                        mul_a = 33'(r3_now);
                        mul_b = {16'd0, amp_reg};
                    end
                    3'd4:
                    begin
                        mul_a = {16'd0, amp_reg};
                        mul_b = {17'd0, roughness_reg};
                    end
                    3'd5:
                    begin
                        div_ctl.step = 1'b1;
                    end
                    default: ;
                endcase
            end
            ST_FIN:
            begin
                // divide by 21 as a reciprocal multiplication
                mul_a = {5'd0, tot10};
                mul_b = RECIP_21;
            end
            ST_SCALE:
            begin
                mul_a = 33'(hq);
                mul_b = {23'd0, height_scale_reg};
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            oct_reg   <= '0;
            sel_reg   <= '0;
            phase_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cnt_reg   <= cnt_eff;
                        oct_reg   <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        sel_reg   <= '0;
                        phase_reg <= '0;
                        state_reg <= (cnt_reg > OCT_W'(1)) ? ST_HASH : ST_FIN;
                    end
                end
                ST_HASH:
                begin
                    if (phase_reg == 3'd3)
                    begin
                        phase_reg <= '0;
                        sel_reg   <= sel_reg + 1'b1;
                        if (sel_reg == 2'd3)
                            state_reg <= ST_BLEND;
                    end
                    else
                        phase_reg <= phase_reg + 1'b1;
                end
                ST_BLEND:
                begin
                    if (phase_reg == 3'd5)
                    begin
                        phase_reg <= '0;
                        oct_reg   <= oct_reg + 1'b1;
                        state_reg <= ((oct_reg + OCT_W'(2)) < cnt_reg) ? ST_HASH : ST_FIN;
                    end
                    else
                        phase_reg <= phase_reg + 1'b1;
                end
                ST_FIN:
                begin
                    state_reg <= ST_FDIV;
                end
                ST_FDIV:
                begin
                    state_reg <= ST_SCALE;
                end
                ST_SCALE:
                begin
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                sign_x_reg <= wx[WW-1];
                sign_z_reg <= wz[WW-1];
                amp_reg    <= 17'd65536;
                total_reg  <= '0;
            end
            ST_HASH:
            begin
                if (phase_reg == 3'd3)
                    corner_reg[sel_reg] <= corner_val;
            end
            ST_BLEND:
            begin
                case (phase_reg)
                    3'd1:    r1_reg    <= r1_now;
                    3'd4:    total_reg <= total_reg + TOTAL_W'(sh16);
                    3'd5:    amp_reg   <= mul_p[32:16];
                    default: ;
                endcase
            end
            ST_FDIV:
            begin
                fq_reg <= mul_p[RECIP_SHIFT+TOTAL_W-1:RECIP_SHIFT];
            end
            ST_OUT:
            begin
                height_reg <= height_val;
            end
            default: ;
        endcase
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign height_q8 = height_reg;
endmodule

// ===== rtl/ovnh_checker.sv =====
`timescale 1ns / 1ps

module ovnh_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);
    // result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // an accepted item makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but block not busy");

    // a result only ends a busy period
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
        else $error("result without work in progress");

    // busy only starts from an accepted item
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy without start");
endmodule

bind octave_value_noise_height_unit ovnh_checker u_ovnh_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
